// ===== hdl/swlrl_pkg.sv =====
// Shared constants for the sliding window log rate limiter.
// Holds item layouts, kind codes and configuration register indexes; no dependencies.
`default_nettype none

package swlrl_pkg;

    localparam int CLIENT_W   = 4;
    localparam int TIME_W     = 32;
    localparam int KIND_W     = 1;
    localparam int COUNT_W    = 5;
    localparam int MAXREQ_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b0;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_LIMIT    = 1'b1;

    localparam logic [TIME_W-1:0]   WINDOW_RESET = 32'd60;
    localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 5'd8;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_log_rate_limiter.sv =====
// Top level of the sliding window log rate limiter: sequencer, timestamp memory
// and per-client head/count memory. Depends on swlrl_pkg.
`default_nettype none

// Each client keeps a ring of up to MAX_LOG allowed timestamps. A request item
// drops expired entries from the front of its client's ring, one entry per cycle
// through a single subtract-and-compare unit, then allows and logs the request if
// the ring holds fewer entries than the configured request limit, capped at
// MAX_LOG. A request passes through the states META_RD, LOAD, POP_CHK (skipped
// when its log is empty), DECIDE and DONE; a clear item through META_RD, LOAD and
// DONE; an item for a client out of range goes straight to DONE. A result waits
// in DONE while the output register still holds an unaccepted result. The block
// takes one item at a time and is ready again the cycle after its result is
// loaded. After reset a clearing pass over all NUM_CLIENTS head/count entries
// empties every log before the first item is accepted; configuration writes are
// taken during that pass.
module sliding_window_log_rate_limiter #(
    parameter int NUM_CLIENTS = 16,
    parameter int MAX_LOG     = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0: client_index[3:0], now_time[35:4], zero padding.
    input  wire logic [swlrl_pkg::S_TDATA_W-1:0]     s_tdata,
    // Fields from bit 0: kind.
    input  wire logic [swlrl_pkg::KIND_W-1:0]        s_tuser,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // Fields from bit 0: allowed[0], log_count[5:1], zero padding.
    output logic [swlrl_pkg::M_TDATA_W-1:0]          m_tdata,

    input  wire logic                                cfg_we,
    input  wire logic [swlrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swlrl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CLI_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int HEAD_W = (MAX_LOG > 1) ? $clog2(MAX_LOG) : 1;
    localparam int CNT_W  = $clog2(MAX_LOG + 1);
    localparam int SUM_W  = $clog2(2 * MAX_LOG);
    localparam int ADDR_W = (NUM_CLIENTS * MAX_LOG > 1) ? $clog2(NUM_CLIENTS * MAX_LOG) : 1;
    localparam int LIM_W  = (CNT_W > swlrl_pkg::COUNT_W) ? CNT_W : swlrl_pkg::COUNT_W;
    localparam int EXT_W  = CLI_W + swlrl_pkg::CLIENT_W;
    localparam int DEPTH  = NUM_CLIENTS * MAX_LOG;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [CNT_W-1:0]  count;
    } meta_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META_RD,
        ST_LOAD,
        ST_POP_CHK,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [CLI_W-1:0]                clr_idx_reg;
    logic [swlrl_pkg::TIME_W-1:0]    window_reg;
    logic [swlrl_pkg::MAXREQ_W-1:0]  max_req_reg;

    logic [swlrl_pkg::KIND_W-1:0]    kind_reg;
    logic [CLI_W-1:0]                client_reg;
    logic [ADDR_W-1:0]               base_reg;
    logic [swlrl_pkg::TIME_W-1:0]    now_reg;
    logic [HEAD_W-1:0]               head_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            res_allowed_reg;
    logic [CNT_W-1:0]                res_count_reg;

    logic                            m_valid_reg;
    logic                            m_allowed_reg;
    logic [swlrl_pkg::COUNT_W-1:0]   m_count_reg;

    meta_t                           meta_mem [NUM_CLIENTS];
    logic [swlrl_pkg::TIME_W-1:0]    stamp_mem [DEPTH];
    meta_t                           meta_q_reg;
    logic [swlrl_pkg::TIME_W-1:0]    stamp_q_reg;

    logic [swlrl_pkg::CLIENT_W-1:0]  in_client;
    logic [swlrl_pkg::TIME_W-1:0]    in_now;
    logic [EXT_W-1:0]                in_client_ext;
    logic                            in_range;

    logic [HEAD_W-1:0]               head_inc;
    logic [HEAD_W-1:0]               rd_head;
    logic [ADDR_W-1:0]               stamp_raddr;
    logic [swlrl_pkg::TIME_W-1:0]    age;
    logic                            expired;
    logic [LIM_W-1:0]                limit;
    logic                            grant;
    logic [SUM_W-1:0]                tail_sum;
    logic [SUM_W-1:0]                tail_wrap;
    logic [ADDR_W-1:0]               stamp_waddr;
    logic                            stamp_we;
    logic                            meta_we;
    logic [CLI_W-1:0]                meta_waddr;
    meta_t                           meta_wdata;
    logic                            out_free;
    logic [LIM_W-1:0]                res_count_ext;

    assign in_client     = s_tdata[swlrl_pkg::CLIENT_W-1:0];
    assign in_now        = s_tdata[swlrl_pkg::CLIENT_W +: swlrl_pkg::TIME_W];
    assign in_client_ext = EXT_W'(in_client);
    assign in_range      = 32'(in_client) < NUM_CLIENTS;

    assign head_inc = (head_reg == HEAD_W'(MAX_LOG - 1)) ? '0 : head_reg + 1'b1;

    always_comb begin
        case (state_reg)
            ST_LOAD:    rd_head = meta_q_reg.head;
            ST_POP_CHK: rd_head = head_inc;
            default:    rd_head = head_reg;
        endcase
    end

    assign stamp_raddr = base_reg + ADDR_W'(rd_head);

    assign age     = now_reg - stamp_q_reg;
    assign expired = age > window_reg;

    assign limit = (LIM_W'(max_req_reg) > LIM_W'(MAX_LOG)) ? LIM_W'(MAX_LOG)
                                                          : LIM_W'(max_req_reg);
    assign grant = LIM_W'(cnt_reg) < limit;

    assign tail_sum    = SUM_W'(head_reg) + SUM_W'(cnt_reg);
    assign tail_wrap   = (tail_sum >= SUM_W'(MAX_LOG)) ? tail_sum - SUM_W'(MAX_LOG) : tail_sum;
    assign stamp_waddr = base_reg + ADDR_W'(tail_wrap);
    assign stamp_we    = (state_reg == ST_DECIDE) && grant;

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = client_reg;
        meta_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = clr_idx_reg;
            end
            ST_LOAD: begin
                meta_we = (kind_reg == swlrl_pkg::KIND_CLEAR);
            end
            ST_DECIDE: begin
                meta_we          = 1'b1;
                meta_wdata.head  = head_reg;
                meta_wdata.count = grant ? cnt_reg + 1'b1 : cnt_reg;
            end
            default: begin
                meta_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_q_reg <= meta_mem[client_reg];
    end

    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[stamp_waddr] <= now_reg;
        end
        stamp_q_reg <= stamp_mem[stamp_raddr];
    end

    assign out_free      = !m_valid_reg || m_tready;
    assign res_count_ext = LIM_W'(res_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            window_reg  <= swlrl_pkg::WINDOW_RESET;
            max_req_reg <= swlrl_pkg::MAXREQ_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    swlrl_pkg::CFG_WINDOW_TICKS: window_reg <= cfg_wdata;
                    swlrl_pkg::CFG_REQ_LIMIT:
                        max_req_reg <= cfg_wdata[swlrl_pkg::MAXREQ_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == CLI_W'(NUM_CLIENTS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg   <= s_tuser;
                        client_reg <= in_client_ext[CLI_W-1:0];
                        base_reg   <= ADDR_W'(32'(in_client_ext[CLI_W-1:0]) * MAX_LOG);
                        now_reg    <= in_now;
                        if (in_range) begin
                            state_reg <= ST_META_RD;
                        end else begin
                            res_allowed_reg <= 1'b0;
                            res_count_reg   <= '0;
                            state_reg       <= ST_DONE;
                        end
                    end
                end
                ST_META_RD: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    head_reg <= meta_q_reg.head;
                    cnt_reg  <= meta_q_reg.count;
                    if (kind_reg == swlrl_pkg::KIND_CLEAR) begin
                        res_allowed_reg <= 1'b0;
                        res_count_reg   <= '0;
                        state_reg       <= ST_DONE;
                    end else if (meta_q_reg.count == '0) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        state_reg <= ST_POP_CHK;
                    end
                end
                ST_POP_CHK: begin
                    if (expired) begin
                        head_reg <= head_inc;
                        cnt_reg  <= cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1)) begin
                            state_reg <= ST_DECIDE;
                        end
                    end else begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    res_allowed_reg <= grant;
                    res_count_reg   <= grant ? cnt_reg + 1'b1 : cnt_reg;
                    state_reg       <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_allowed_reg <= res_allowed_reg;
                        m_count_reg   <= res_count_ext[swlrl_pkg::COUNT_W-1:0];
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(swlrl_pkg::M_TDATA_W - swlrl_pkg::COUNT_W - 1)'(0),
                       m_count_reg, m_allowed_reg};

endmodule

`default_nettype wire
